// ===== sv/iice_pkg.sv =====
// ----------------------------------------------------------------------------
// iice_pkg: shared types and constants of the image intake CRC engine
// Opcodes, phase codes, register indexes, the result job record and the
// byte-wide CRC-32 update (reflected, polynomial 0xEDB88320).
// ----------------------------------------------------------------------------
package iice_pkg;

  // item opcodes
  typedef enum logic [1:0] {
    OP_START  = 2'd0,
    OP_DATA   = 2'd1,
    OP_FINISH = 2'd2,
    OP_ABORT  = 2'd3
  } op_t;

  // intake phase
  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_RECV = 2'd1,
    PH_DONE = 2'd2,
    PH_ERR  = 2'd3
  } phase_t;

  // configuration register indexes
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 20;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT_SELECT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_SIZE  = 1'b1;

  // field widths
  localparam int SIZE_W = 20;
  localparam int ADDR_W = 24;
  localparam int WORD_W = 32;

  // fixed constants
  localparam logic [31:0]       CRC_POLY       = 32'hEDB8_8320;
  localparam logic [31:0]       CRC_ALL_ONES   = 32'hFFFF_FFFF;
  localparam logic [31:0]       MANIFEST_MAGIC = 32'h3143_5746;
  localparam logic [ADDR_W-1:0] SLOT0_BASE     = 24'hD0_0000;
  localparam logic [ADDR_W-1:0] SLOT1_BASE     = 24'hE0_0000;
  localparam logic [ADDR_W-1:0] DATA_OFFSET    = 24'h00_1000;
  localparam logic [SIZE_W-1:0] SIZE_MAX_BYTES = 20'hB_9000;
  localparam logic [SIZE_W-1:0] SIZE_MIN_BYTES = 20'h0_2000;

  // one job handed from the item logic to the output stage
  typedef struct packed {
    logic              manifest;    // expands into four manifest words
    logic              wr_valid;
    logic [ADDR_W-1:0] addr;        // slot base for a manifest
    logic [WORD_W-1:0] value;       // final crc for a manifest
    logic [SIZE_W-1:0] size;        // image size for a manifest
    logic              sector_end;
    phase_t            state;
  } iice_job_t;

  // fold one byte into the reflected crc
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                           input logic [7:0]  data);
    logic [31:0] c;
    c = crc_in ^ {24'h0, data};
    for (int b = 0; b < 8; b++) begin
      c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
    end
    return c;
  endfunction

endpackage

// ===== sv/image_intake_crc_engine_top.sv =====
// ----------------------------------------------------------------------------
// image_intake_crc_engine_top: firmware image intake with running CRC-32
// Start, data, finish and abort items drive the intake; data bytes leave as
// flash writes, finish leaves as four manifest words.
// ----------------------------------------------------------------------------
// Start, data and abort items can follow one another in every cycle while
// results are taken; each gives one transfer through the item and result
// registers. A finish that completes the image gives four transfers, so the
// result stage holds the next item until the last is taken; that stage sets
// the rate. Every data byte's crc update is an eight-step xor network
// between item and state registers. No clearing pass is needed after reset.
module image_intake_crc_engine_top #(
  parameter int SECTOR_BYTES = 4096
) (
  input  logic                            clk,
  input  logic                            rst,
  // configuration write channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [iice_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [iice_pkg::CFG_DATA_W-1:0] cfg_data,
  // item stream
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [7:0]                      s_tdata,  // [7:0] data_byte
  input  logic [1:0]                      s_tuser,  // [1:0] opcode
  // result stream
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // [23:0] flash_address, [55:24] write_value, [56] sector_end,
  // [58:57] intake_state, [63:59] zero
  output logic [63:0]                     m_tdata,
  // [0] write_valid, [1] value_is_word
  output logic [1:0]                      m_tuser,
  output logic                            m_tlast
);
  import iice_pkg::*;

  logic      in_valid;
  op_t       in_op;
  logic [7:0] in_byte;
  logic      can_load;
  logic      go;
  iice_job_t job;

  assign go       = in_valid && can_load;
  assign s_tready = !in_valid || go;

  // item register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (go) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_op   <= op_t'(s_tuser);
      in_byte <= s_tdata;
    end
  end

  iice_core #(
    .SECTOR_BYTES(SECTOR_BYTES)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .go        (go),
    .item_op   (in_op),
    .item_byte (in_byte),
    .job       (job)
  );

  iice_out u_out (
    .clk       (clk),
    .rst       (rst),
    .job_valid (in_valid),
    .job_in    (job),
    .can_load  (can_load),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule

// ===== sv/iice_core.sv =====
// ----------------------------------------------------------------------------
// iice_core: intake state and per-item logic
// Holds the configuration registers, phase, byte count, sector count and
// running crc; turns the registered item into one job for the output stage.
// ----------------------------------------------------------------------------
module iice_core #(
  parameter int SECTOR_BYTES = 4096
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [iice_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [iice_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                          go,
  input  iice_pkg::op_t                 item_op,
  input  logic [7:0]                    item_byte,
  output iice_pkg::iice_job_t           job
);
  import iice_pkg::*;

  localparam int SEC_W = $clog2(SECTOR_BYTES);
  localparam logic [SEC_W-1:0] SEC_LAST = SEC_W'(SECTOR_BYTES - 1);

  logic              slot_select;
  logic [SIZE_W-1:0] image_size;
  phase_t            phase, phase_next;
  logic [SIZE_W-1:0] bytes_written, bytes_written_next;
  logic [SEC_W-1:0]  sec_cnt, sec_cnt_next;
  logic [31:0]       running_crc, running_crc_next;
  logic              held_slot, held_slot_next;
  logic [SIZE_W-1:0] held_size, held_size_next;
  logic              size_bad;
  logic [ADDR_W-1:0] base;

  assign cfg_ready = 1'b1;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_select <= 1'b0;
      image_size  <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SLOT_SELECT: slot_select <= cfg_data[0];
        REG_IMAGE_SIZE:  image_size  <= cfg_data[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  assign size_bad = (image_size < SIZE_MIN_BYTES) || (image_size > SIZE_MAX_BYTES) ||
                    image_size[0];
  assign base     = held_slot ? SLOT1_BASE : SLOT0_BASE;

  // next state and job for the current item
  always_comb begin
    phase_next         = phase;
    bytes_written_next = bytes_written;
    sec_cnt_next       = sec_cnt;
    running_crc_next   = running_crc;
    held_slot_next     = held_slot;
    held_size_next     = held_size;
    job                = '0;
    case (item_op)
      OP_START: begin
        bytes_written_next = '0;
        sec_cnt_next       = '0;
        if (size_bad) begin
          phase_next = PH_ERR;
        end else begin
          held_slot_next   = slot_select;
          held_size_next   = image_size;
          running_crc_next = CRC_ALL_ONES;
          phase_next       = PH_RECV;
        end
      end
      OP_DATA: begin
        if (phase == PH_RECV && bytes_written < held_size) begin
          running_crc_next   = crc_byte(running_crc, item_byte);
          bytes_written_next = bytes_written + 1'b1;
          sec_cnt_next       = (sec_cnt == SEC_LAST) ? '0 : sec_cnt + 1'b1;
          job.wr_valid       = 1'b1;
          job.addr           = base + DATA_OFFSET + {{(ADDR_W-SIZE_W){1'b0}}, bytes_written};
          job.value          = {24'h0, item_byte};
          job.sector_end     = (sec_cnt == SEC_LAST) || (bytes_written_next == held_size);
        end
      end
      OP_FINISH: begin
        if (phase == PH_RECV && bytes_written == held_size) begin
          phase_next   = PH_DONE;
          job.manifest = 1'b1;
          job.wr_valid = 1'b1;
          job.addr     = base;
          job.value    = running_crc ^ CRC_ALL_ONES;
          job.size     = held_size;
        end else if (phase == PH_RECV || phase == PH_IDLE) begin
          phase_next = PH_ERR;
        end
      end
      OP_ABORT: begin
        if (phase == PH_RECV || phase == PH_IDLE) begin
          phase_next = PH_ERR;
        end
      end
      default: ;
    endcase
    job.state = phase_next;
  end

  // state update when the item moves on
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      bytes_written <= '0;
      sec_cnt       <= '0;
      running_crc   <= CRC_ALL_ONES;
      held_slot     <= 1'b0;
      held_size     <= '0;
    end else if (go) begin
      phase         <= phase_next;
      bytes_written <= bytes_written_next;
      sec_cnt       <= sec_cnt_next;
      running_crc   <= running_crc_next;
      held_slot     <= held_slot_next;
      held_size     <= held_size_next;
    end
  end

endmodule

// ===== sv/iice_out.sv =====
// ----------------------------------------------------------------------------
// iice_out: result register and manifest sequencer
// Holds one job; a plain job leaves as one transfer, a manifest job as four
// word transfers (magic, size, crc, zero) at base, base+4, base+8, base+12.
// ----------------------------------------------------------------------------
module iice_out (
  input  logic                clk,
  input  logic                rst,
  input  logic                job_valid,
  input  iice_pkg::iice_job_t job_in,
  output logic                can_load,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [63:0]         m_tdata,
  output logic [1:0]          m_tuser,
  output logic                m_tlast
);
  import iice_pkg::*;

  logic        out_valid;
  iice_job_t   job;
  logic [1:0]  beat;
  logic        last;
  logic        xfer;
  logic        load;
  logic [ADDR_W-1:0] addr;
  logic [WORD_W-1:0] value;

  assign last     = !job.manifest || (beat == 2'd3);
  assign xfer     = out_valid && m_tready;
  assign can_load = !out_valid || (m_tready && last);
  assign load     = can_load && job_valid;

  // result register and beat counter
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      beat      <= '0;
    end else if (load) begin
      out_valid <= 1'b1;
      beat      <= '0;
    end else if (xfer && last) begin
      out_valid <= 1'b0;
    end else if (xfer) begin
      beat <= beat + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      job <= job_in;
    end
  end

  // manifest word select
  always_comb begin
    addr  = job.addr;
    value = job.value;
    if (job.manifest) begin
      addr = job.addr + {{(ADDR_W-4){1'b0}}, beat, 2'b00};
      case (beat)
        2'd0:    value = MANIFEST_MAGIC;
        2'd1:    value = {{(WORD_W-SIZE_W){1'b0}}, job.size};
        2'd2:    value = job.value;
        default: value = '0;
      endcase
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {5'b0, job.state, job.sector_end, value, addr};
  assign m_tuser  = {job.manifest, job.wr_valid};
  assign m_tlast  = last;

endmodule

// ===== verif/image_intake_crc_engine_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// image_intake_crc_engine_top_tb: self-checking bench of the image intake engine
// Drives start, data, finish and abort items with random gaps on both
// streams, predicts every flash write, manifest word and status transfer
// with its own copy of the intake state and running crc, and compares each
// result transfer field by field. Covers size checks at both ends, restarts,
// short finishes and broken or noisy sequences.
// ----------------------------------------------------------------------------
module image_intake_crc_engine_top_tb;
  import iice_pkg::*;

  localparam int          SECTOR      = 4096;
  localparam int unsigned IDLE_LIMIT  = 2000;
  localparam int unsigned TAIL_CYCLES = 20;

  localparam logic [23:0] FLASH_SLOT0    = 24'hD0_0000;
  localparam logic [23:0] FLASH_SLOT1    = 24'hE0_0000;
  localparam logic [23:0] IMAGE_AREA     = 24'h00_1000;
  localparam logic [31:0] MANIFEST_ID    = 32'h3143_5746;
  localparam logic [31:0] REFLECTED_POLY = 32'hEDB8_8320;
  localparam logic [19:0] IMAGE_MIN      = 20'd8192;
  localparam logic [19:0] IMAGE_MAX      = 20'hB_9000;

  // one result transfer, with the port fields in the order the monitor packs them
  typedef struct packed {
    logic        wr;
    logic [23:0] addr;
    logic [31:0] value;
    logic        word;
    logic        send;
    phase_t      state;
    logic        last;
  } flash_rec_t;

  // predicts flash writes and status transfers, checks them in order
  class flash_write_tracker;
    logic        cfg_slot   = 1'b0;
    logic [19:0] cfg_size   = '0;
    logic        held_slot  = 1'b0;
    logic [19:0] held_size  = '0;
    logic [19:0] byte_count = '0;
    logic [31:0] crc        = '1;
    phase_t      intake     = PH_IDLE;
    flash_rec_t  pending_writes[$];
    int unsigned mismatches = 0;

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx == REG_SLOT_SELECT) cfg_slot = val[0];
      else if (idx == REG_IMAGE_SIZE) cfg_size = val;
    endfunction

    // reflected crc-32, one bit per step
    function logic [31:0] crc32_fold(logic [31:0] c, logic [7:0] b);
      logic [31:0] r;
      r = c ^ {24'h0, b};
      for (int i = 0; i < 8; i++) r = r[0] ? ((r >> 1) ^ REFLECTED_POLY) : (r >> 1);
      return r;
    endfunction

    function void push(logic wr, logic [23:0] addr, logic [31:0] value, logic word,
                       logic send, logic last);
      flash_rec_t rec;
      rec = '{wr, addr, value, word, send, intake, last};
      pending_writes.push_back(rec);
    endfunction

    function void take_item(op_t op, logic [7:0] data);
      logic [23:0] base;
      logic        send;
      base = held_slot ? FLASH_SLOT1 : FLASH_SLOT0;
      case (op)
        OP_START: begin
          byte_count = '0;
          if (cfg_size < IMAGE_MIN || cfg_size > IMAGE_MAX || cfg_size[0]) begin
            intake = PH_ERR;
          end else begin
            held_slot = cfg_slot;
            held_size = cfg_size;
            crc       = '1;
            intake    = PH_RECV;
          end
        end
        OP_DATA: begin
          // bytes outside receiving or past the image end fall through to status
          if (intake == PH_RECV && byte_count < held_size) begin
            crc        = crc32_fold(crc, data);
            byte_count = byte_count + 1'b1;
            send       = (byte_count % SECTOR == 0) || (byte_count == held_size);
            push(1'b1, base + IMAGE_AREA + 24'(byte_count - 1'b1), {24'h0, data},
                 1'b0, send, 1'b1);
            return;
          end
        end
        OP_FINISH: begin
          if (intake == PH_RECV && byte_count == held_size) begin
            intake = PH_DONE;
            push(1'b1, base,         MANIFEST_ID,       1'b1, 1'b0, 1'b0);
            push(1'b1, base + 24'd4, {12'h0, held_size}, 1'b1, 1'b0, 1'b0);
            push(1'b1, base + 24'd8, ~crc,              1'b1, 1'b0, 1'b0);
            push(1'b1, base + 24'd12, 32'h0,            1'b1, 1'b0, 1'b1);
            return;
          end
          if (intake == PH_RECV || intake == PH_IDLE) intake = PH_ERR;
        end
        default: begin
          if (intake == PH_RECV || intake == PH_IDLE) intake = PH_ERR;
        end
      endcase
      push(1'b0, '0, '0, 1'b0, 1'b0, 1'b1);
    endfunction

    function void check_write(flash_rec_t got);
      flash_rec_t want;
      if (pending_writes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result wr=%0d addr=%06h val=%08h word=%0d send=%0d st=%0d last=%0d",
                   $time, got.wr, got.addr, got.value, got.word, got.send, got.state, got.last);
        return;
      end
      want = pending_writes.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: mismatch exp wr=%0d addr=%06h val=%08h word=%0d send=%0d st=%0d last=%0d",
                   $time, want.wr, want.addr, want.value, want.word, want.send, want.state,
                   want.last);
          $display("%0t:          got wr=%0d addr=%06h val=%08h word=%0d send=%0d st=%0d last=%0d",
                   $time, got.wr, got.addr, got.value, got.word, got.send, got.state, got.last);
        end
      end
    endfunction

    function int unsigned pending();
      return pending_writes.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst       = 1'b1;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [7:0]            s_tdata   = '0;
  logic [1:0]            s_tuser   = '0;
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [63:0]           m_tdata;
  logic [1:0]            m_tuser;
  logic                  m_tlast;

  flash_write_tracker tracker = new;
  flash_rec_t         seen;
  bit                 gaps_on      = 1'b1;
  int unsigned        stall_left   = 0;
  int unsigned        quiet_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  image_intake_crc_engine_top #(
    .SECTOR_BYTES(SECTOR)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // mostly short gaps, a few long ones
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // receiver stalls
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      m_tready   <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      if (gaps_on && $urandom_range(0, 99) < 20) stall_left <= gap_len();
    end
  end

  // result monitor
  assign seen = {m_tuser[0], m_tdata[23:0], m_tdata[55:24], m_tuser[1], m_tdata[56],
                 m_tdata[58:57], m_tlast};

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) tracker.check_write(seen);
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_item(op_t op, logic [7:0] data);
    int unsigned gap;
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= data;
    do @(posedge clk); while (!s_tready);
    tracker.take_item(op, data);
    gap = gaps_on ? gap_len() : 0;
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    tracker.write_reg(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // stop sending and let every expected result come out
  task automatic drain_results();
    if (s_tvalid) s_tvalid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(logic slot, logic [19:0] size);
    write_reg(REG_SLOT_SELECT, CFG_DATA_W'(slot));
    write_reg(REG_IMAGE_SIZE, size);
  endtask

  // random sizes and short sequences of mixed items
  task automatic noise_phase();
    int unsigned r;
    logic [19:0] size;
    op_t         op;
    drain_results();
    r = $urandom_range(0, 99);
    if (r < 60)      size = IMAGE_MIN + 20'(2 * $urandom_range(0, 32));
    else if (r < 70) size = IMAGE_MAX;
    else if (r < 80) size = 20'($urandom);
    else if (r < 90) size = 20'($urandom_range(0, 8191));
    else if (r < 95) size = IMAGE_MIN + 20'(2 * $urandom_range(0, 1000) + 1);
    else             size = 20'($urandom_range(IMAGE_MAX + 1, 20'hF_FFFF));
    set_config(1'($urandom_range(0, 1)), size);
    send_item(OP_START, 8'($urandom));
    repeat (12) begin
      r = $urandom_range(0, 99);
      if (r < 75)      op = OP_DATA;
      else if (r < 83) op = OP_START;
      else if (r < 91) op = OP_FINISH;
      else             op = OP_ABORT;
      send_item(op, 8'($urandom));
    end
  endtask

  initial begin
    logic [19:0] bad_sizes [4];
    bad_sizes = '{20'hF_FFFF, IMAGE_MAX + 20'd2, IMAGE_MIN - 20'd2, IMAGE_MIN + 20'd1};
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: idle behavior, then a finish or an abort while idle
    send_item(OP_DATA, 8'hFF);
    if ($urandom_range(0, 1)) send_item(OP_FINISH, 8'h00);
    else send_item(OP_ABORT, 8'h00);
    send_item(OP_ABORT, 8'h00);
    send_item(OP_START, 8'h00);

    // directed: rejected sizes beyond both limits and an odd size
    foreach (bad_sizes[i]) begin
      drain_results();
      write_reg(REG_IMAGE_SIZE, bad_sizes[i]);
      send_item(OP_START, 8'h00);
    end

    // directed: largest image, restart while receiving, short finish, error behavior
    drain_results();
    set_config(1'b1, IMAGE_MAX);
    send_item(OP_START, 8'h00);
    send_item(OP_DATA, 8'h00);
    send_item(OP_DATA, 8'hFF);
    send_item(OP_DATA, 8'h5A);
    send_item(OP_START, 8'hFF);
    send_item(OP_DATA, 8'hA5);
    send_item(OP_FINISH, 8'h00);
    send_item(OP_DATA, 8'h3C);
    send_item(OP_FINISH, 8'h00);
    send_item(OP_ABORT, 8'h00);
    send_item(OP_START, 8'h00);
    send_item(OP_ABORT, 8'h00);

    // random: noisy phases of mixed items
    for (int p = 0; p < 11; p++) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      noise_phase();
    end

    gaps_on = 1'b1;
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
